/* rtl/core/pfa_pkg.sv */
// Shared types, widths and helper function of the page frame allocator.
`default_nettype none

package pfa_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BIT_W         = 5;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned PG_W          = 12;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned MAX_PAGES_DEF = 4096;
  localparam int unsigned TOTAL_RST     = 4096;
  localparam int unsigned RESERVED_RST  = 1;

  typedef enum logic [1:0] {
    CMD_RESERVE = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_NO_FREE     = 3'd2,
    ST_DOUBLE_FREE = 3'd3,
    ST_RANGE       = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_RES  = 8'b0000_0100,
    S_FCHK = 8'b0000_1000,
    S_FMOD = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_AMOD = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/pfa_if.sv */
// Handshake interfaces for request, response and configuration channels.
`default_nettype none

interface pfa_req_if;
  logic                      valid;
  logic                      ready;
  pfa_pkg::cmd_e             command;
  logic [pfa_pkg::CNT_W-1:0] count;
  logic [pfa_pkg::PG_W-1:0]  page;

  modport source (output valid, command, count, page, input ready);
  modport sink   (input valid, command, count, page, output ready);
endinterface

interface pfa_rsp_if;
  logic                      valid;
  logic                      ready;
  pfa_pkg::status_e          status;
  logic [pfa_pkg::IDX_W-1:0] page_index;

  modport source (output valid, status, page_index, input ready);
  modport sink   (input valid, status, page_index, output ready);
endinterface

interface pfa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [pfa_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/pfa_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pfa_ram #(
  parameter int unsigned WIDTH = pfa_pkg::WORD_W,
  parameter int unsigned DEPTH = pfa_pkg::MAX_PAGES_DEF / pfa_pkg::WORD_W
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/pfa_summary.sv */
// Per-row free summary bits with a chunked lowest-row search.
`default_nettype none

module pfa_summary #(
  parameter int unsigned NW = pfa_pkg::MAX_PAGES_DEF / pfa_pkg::WORD_W,
  parameter int unsigned NC = (NW + pfa_pkg::WORD_W - 1) / pfa_pkg::WORD_W
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    upd_en_i,
  input  wire logic [((NW > 1) ? $clog2(NW) : 1)-1:0]  upd_row_i,
  input  wire logic                                    upd_any_i,
  input  wire logic [((NC > 1) ? $clog2(NC) : 1)-1:0]  chunk_i,
  output logic                                         hit_o,
  output logic      [((NW > 1) ? $clog2(NW) : 1)-1:0]  row_o
);

  import pfa_pkg::*;

  localparam int unsigned RW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned KW = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned SW = KW + BIT_W;

  logic [NW-1:0]        bits_q;
  logic [NC*WORD_W-1:0] padded;
  logic [WORD_W-1:0]    chunks [NC];
  logic [WORD_W-1:0]    cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '1;
    end else if (upd_en_i) begin
      bits_q[upd_row_i] <= upd_any_i;
    end
  end

  assign padded = (NC * WORD_W)'(bits_q);

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      chunks[c] = padded[c*WORD_W +: WORD_W];
    end
  end

  assign cur   = chunks[chunk_i];
  assign hit_o = |cur;
  assign row_o = RW'(SW'({chunk_i, lowest_set(cur)}));

endmodule

`default_nettype wire

/* rtl/core/page_frame_allocator_unit.sv */
// Page frame allocator: one item at a time, bitmap in RAM words, row summary search.
// Reserve checks the new sum against the limit; free checks the range, reads the row and
// sets the page's bit; allocate scans 1 .. ceil(rows/32) summary chunks, reads the row
// found and clears its lowest free bit, or gives no-free after the last chunk. Unused codes
// complete at once. The next item can be accepted while its result is valid; a result
// waiting holds the next one back. After reset every row is set free before items are taken.
`default_nettype none

module page_frame_allocator_unit #(
  parameter int unsigned MAX_PAGES = pfa_pkg::MAX_PAGES_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pfa_req_if.sink   req_i,
  pfa_rsp_if.source rsp_o,
  pfa_cfg_if.sink   cfg_i
);

  import pfa_pkg::*;

  localparam int unsigned NW  = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned NC  = (NW + WORD_W - 1) / WORD_W;
  localparam int unsigned RW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned KW  = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned IW  = RW + BIT_W;
  localparam int unsigned CW  = (IW + 1 > CNT_W + 1) ? IW + 1 : CNT_W + 1;
  localparam logic [CW-1:0] MAX_C   = CW'(MAX_PAGES);
  localparam logic [CW-1:0] EFF_RST = CW'((TOTAL_RST > MAX_PAGES) ? MAX_PAGES : TOTAL_RST);

  state_e             state_q, state_d;
  logic [RW-1:0]      init_row_q, init_row_d;
  logic [KW-1:0]      chunk_q, chunk_d;
  logic               out_valid_q, out_valid_d;
  logic [CNT_W-1:0]   reserved_q, reserved_d;
  logic [CW-1:0]      eff_q, eff_d;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [PG_W-1:0]    page_q, page_d;
  logic [RW-1:0]      row_q, row_d;
  status_e            res_status_q, res_status_d;
  logic [IDX_W-1:0]   res_index_q, res_index_d;
  status_e            out_status_q, out_status_d;
  logic [IDX_W-1:0]   out_index_q, out_index_d;

  logic               ram_we, ram_re;
  logic [RW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic               sum_upd, sum_any, sum_hit;
  logic [RW-1:0]      sum_row;

  logic [CW-1:0]      cfg_ext;
  logic [CW-1:0]      page_ext;
  logic [RW-1:0]      page_row;
  logic [WORD_W-1:0]  page_mask;
  logic [BIT_W-1:0]   hit_bit;
  logic [IW-1:0]      alloc_idx;
  logic [WORD_W-1:0]  alloc_mask;
  logic [CNT_W:0]     res_sum;

  pfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pfa_summary #(
    .NW (NW),
    .NC (NC)
  ) u_summary (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_en_i  (sum_upd),
    .upd_row_i (ram_waddr),
    .upd_any_i (sum_any),
    .chunk_i   (chunk_q),
    .hit_o     (sum_hit),
    .row_o     (sum_row)
  );

  assign req_i.ready      = (state_q == S_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.page_index = out_index_q;

  assign cfg_ext    = CW'(cfg_i.data);
  assign page_ext   = CW'(page_q);
  assign page_row   = page_ext[IW-1:BIT_W];
  assign page_mask  = WORD_W'(1) << page_q[BIT_W-1:0];
  assign hit_bit    = lowest_set(ram_rdata);
  assign alloc_idx  = {row_q, hit_bit};
  assign alloc_mask = WORD_W'(1) << hit_bit;
  assign res_sum    = {1'b0, reserved_q} + {1'b0, count_q};

  always_comb begin
    state_d      = state_q;
    init_row_d   = init_row_q;
    chunk_d      = chunk_q;
    out_valid_d  = out_valid_q;
    reserved_d   = reserved_q;
    eff_d        = eff_q;
    count_d      = count_q;
    page_d       = page_q;
    row_d        = row_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    ram_we       = 1'b0;
    ram_waddr    = row_q;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = row_q;
    sum_upd      = 1'b0;
    sum_any      = 1'b0;

    if (cfg_i.valid) begin
      eff_d = (cfg_ext > MAX_C) ? MAX_C : cfg_ext;
    end

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_row_q;
        ram_wdata = '1;
        if (init_row_q == RW'(NW - 1)) begin
          state_d = S_IDLE;
        end else begin
          init_row_d = init_row_q + RW'(1);
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          count_d     = req_i.count;
          page_d      = req_i.page;
          chunk_d     = '0;
          res_index_d = '0;
          unique case (req_i.command)
            CMD_RESERVE: state_d = S_RES;
            CMD_ALLOC:   state_d = S_SCAN;
            CMD_FREE:    state_d = S_FCHK;
            default: begin
              res_status_d = ST_OK;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_RES: begin
        if (CW'(res_sum) <= eff_q) begin
          reserved_d   = res_sum[CNT_W-1:0];
          res_status_d = ST_OK;
        end else begin
          res_status_d = ST_REFUSED;
        end
        state_d = S_DONE;
      end
      S_FCHK: begin
        if (page_ext >= eff_q) begin
          res_status_d = ST_RANGE;
          state_d      = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = page_row;
          state_d   = S_FMOD;
        end
      end
      S_FMOD: begin
        if ((ram_rdata & page_mask) != '0) begin
          res_status_d = ST_DOUBLE_FREE;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = page_row;
          ram_wdata    = ram_rdata | page_mask;
          sum_upd      = 1'b1;
          sum_any      = 1'b1;
          res_status_d = ST_OK;
          if (reserved_q != '0) begin
            reserved_d = reserved_q - CNT_W'(1);
          end
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (sum_hit) begin
          ram_re    = 1'b1;
          ram_raddr = sum_row;
          row_d     = sum_row;
          state_d   = S_AMOD;
        end else if (chunk_q == KW'(NC - 1)) begin
          res_status_d = ST_NO_FREE;
          state_d      = S_DONE;
        end else begin
          chunk_d = chunk_q + KW'(1);
        end
      end
      S_AMOD: begin
        if (CW'(alloc_idx) >= eff_q) begin
          res_status_d = ST_NO_FREE;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = row_q;
          ram_wdata    = ram_rdata & ~alloc_mask;
          sum_upd      = 1'b1;
          sum_any      = |(ram_rdata & ~alloc_mask);
          res_status_d = ST_OK;
          res_index_d  = IDX_W'(alloc_idx);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = res_index_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_row_q  <= '0;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
      reserved_q  <= CNT_W'(RESERVED_RST);
      eff_q       <= EFF_RST;
    end else begin
      state_q     <= state_d;
      init_row_q  <= init_row_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
      reserved_q  <= reserved_d;
      eff_q       <= eff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q      <= count_d;
    page_q       <= page_d;
    row_q        <= row_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
  end

`ifndef NO_ASSERTIONS
  a_row_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AMOD |-> ram_rdata != '0)
    else $error("summary pointed at a full row");

  a_free_sets_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FMOD && ram_we) |->
      $countones(ram_wdata) == $countones(ram_rdata) + 1)
    else $error("free changed other than one bit");

  a_alloc_clears_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AMOD && ram_we) |->
      $countones(ram_wdata) + 1 == $countones(ram_rdata))
    else $error("allocate changed other than one bit");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside completion");
`endif

endmodule

`default_nettype wire
